>>> rtl/core/pmux_pkg.sv
`timescale 1ns / 1ps
package pmux_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int SET_W       = 11;

    localparam logic       KIND_RELEASE = 1'b1;
    localparam logic [4:0] PIN_MAX      = 5'd15;
    localparam logic [1:0] MODE_INPUT   = 2'd0;
    localparam logic [1:0] MODE_ALT     = 2'd2;
    localparam logic [1:0] EDGE_NONE    = 2'd0;
    localparam logic [1:0] EDGE_RISE    = 2'd1;
    localparam logic [1:0] EDGE_FALL    = 2'd2;
    localparam logic [1:0] EDGE_BOTH    = 2'd3;
    localparam logic [3:0] PIN_MID_LO   = 4'd5;
    localparam logic [3:0] PIN_HIGH_LO  = 4'd10;
    localparam logic [2:0] GROUP_MID    = 3'd5;
    localparam logic [2:0] GROUP_HIGH   = 3'd6;

    localparam logic [SET_W-1:0] SET_MASK_BASE = 11'h07F;
    localparam logic [SET_W-1:0] SET_MASK_ALT  = 11'h7FF;

    typedef struct packed {
        logic       kind;
        logic [3:0] port;
        logic [4:0] pin;
        logic [1:0] mode;
        logic       open_drain;
        logic [1:0] speed;
        logic [1:0] pull;
        logic [3:0] alt_func;
        logic [1:0] edge_mode;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [31:0] mode_word;
        logic [15:0] otype_word;
        logic [31:0] speed_word;
        logic [31:0] pull_word;
        logic [63:0] altfunc_word;
        logic [63:0] line_source;
        logic [15:0] rise_mask;
        logic [15:0] fall_mask;
        logic [15:0] line_enable;
        logic        irq_valid;
        logic [2:0]  irq_group;
    } res_t;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_RELEASE,
        OP_BAD_PORT,
        OP_BAD_PIN
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] port;
        logic [3:0] pin;
        logic [1:0] mode;
        logic       open_drain;
        logic [1:0] speed;
        logic [1:0] pull;
        logic [3:0] alt_func;
        logic [1:0] edge_mode;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } q_status_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

>>> rtl/core/pmux_queue.sv
`timescale 1ns / 1ps
module pmux_queue
    import pmux_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_data,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    cmd_t                  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W:0]       count_reg;
    logic [QPTR_W-1:0]     wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_next;
    logic [QPTR_W:0]       count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head              = entry_reg[rd_ptr_reg];
    assign status.full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.head_valid = (count_reg != '0);

endmodule

>>> rtl/core/pmux_front.sv
`timescale 1ns / 1ps
module pmux_front
    import pmux_pkg::*;
#(
    parameter int PORTS = 9
)
(
    input  req_t      req_data,
    output cmd_t      cmd
);

    always_comb
    begin
        cmd.port       = req_data.port;
        cmd.pin        = req_data.pin[3:0];
        cmd.mode       = req_data.mode;
        cmd.open_drain = req_data.open_drain;
        cmd.speed      = req_data.speed;
        cmd.pull       = req_data.pull;
        cmd.alt_func   = req_data.alt_func;
        cmd.edge_mode  = req_data.edge_mode;
        priority if ({1'b0, req_data.port} >= 5'(PORTS))
        begin
            cmd.op = OP_BAD_PORT;
        end
        else if (req_data.pin > PIN_MAX)
        begin
            cmd.op = OP_BAD_PIN;
        end
        else if (req_data.kind == KIND_RELEASE)
        begin
            cmd.op = OP_RELEASE;
        end
        else
        begin
            cmd.op = OP_REQUEST;
        end
    end

endmodule

>>> rtl/core/pmux_back.sv
`timescale 1ns / 1ps
module pmux_back
    import pmux_pkg::*;
#(
    parameter int PORTS = 9
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      head,
    input  q_status_t q_status,
    output logic      pop,
    output logic      res_valid,
    input  logic      res_stall,
    output res_t      res_data
);

    localparam int DEPTH  = PORTS * 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int PORT_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    back_state_t       state_reg;
    back_state_t       state_next;

    logic [SET_W-1:0]  settings_mem [DEPTH];
    logic [SET_W-1:0]  rd_data_reg;
    logic [DEPTH-1:0]  alloc_reg;
    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [31:0]       mode_img_reg    [PORTS];
    logic [15:0]       otype_img_reg   [PORTS];
    logic [31:0]       speed_img_reg   [PORTS];
    logic [31:0]       pull_img_reg    [PORTS];
    logic [63:0]       altfunc_img_reg [PORTS];
    logic [63:0]       source_reg;
    logic [15:0]       rise_reg;
    logic [15:0]       fall_reg;
    logic [15:0]       enable_reg;

    logic              res_valid_reg;
    res_t              res_reg;

    logic              done;
    logic              fire;
    logic [IDX_W-1:0]  rd_idx;
    logic [PORT_W-1:0] port_sel;
    logic              port_ok;
    logic              pin_ok;
    logic              alloc_hit;
    logic              do_alloc;
    logic              do_irq;
    logic              mismatch;
    logic [SET_W-1:0]  new_set;
    logic [SET_W-1:0]  cmp_mask;
    logic [4:0]        sh2;
    logic [5:0]        sh4;
    logic [15:0]       pin_bit;
    logic [31:0]       mode_cur;
    logic [15:0]       otype_cur;
    logic [31:0]       speed_cur;
    logic [31:0]       pull_cur;
    logic [63:0]       altfunc_cur;
    logic [31:0]       mode_new;
    logic [15:0]       otype_new;
    logic [31:0]       speed_new;
    logic [31:0]       pull_new;
    logic [63:0]       altfunc_new;
    logic [63:0]       source_new;
    logic [15:0]       rise_new;
    logic [15:0]       fall_new;
    logic [15:0]       enable_new;
    logic [2:0]        group;
    res_t              res_next;

    assign done   = !res_valid_reg || !res_stall;
    assign rd_idx = IDX_W'({head.port, head.pin});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_status.head_valid)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (done && !q_status.head_valid)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        fire = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = q_status.head_valid;
            end
            BK_EXEC:
            begin
                fire = done;
                pop  = done && q_status.head_valid;
            end
            default:
            begin
                pop  = 1'b0;
                fire = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        port_sel    = cmd_reg.port[PORT_W-1:0];
        port_ok     = (cmd_reg.op != OP_BAD_PORT);
        pin_ok      = port_ok && (cmd_reg.op != OP_BAD_PIN);
        alloc_hit   = alloc_reg[idx_reg];
        do_alloc    = (cmd_reg.op == OP_REQUEST) && !alloc_hit;
        do_irq      = do_alloc && (cmd_reg.mode == MODE_INPUT)
                      && (cmd_reg.edge_mode != EDGE_NONE);
        new_set     = {cmd_reg.alt_func, cmd_reg.pull, cmd_reg.speed,
                       cmd_reg.open_drain, cmd_reg.mode};
        cmp_mask    = (cmd_reg.mode == MODE_ALT) ? SET_MASK_ALT : SET_MASK_BASE;
        mismatch    = ((rd_data_reg ^ new_set) & cmp_mask) != '0;
        sh2         = {cmd_reg.pin, 1'b0};
        sh4         = {cmd_reg.pin, 2'b00};
        pin_bit     = 16'(1) << cmd_reg.pin;

        if (port_ok)
        begin
            mode_cur    = mode_img_reg[port_sel];
            otype_cur   = otype_img_reg[port_sel];
            speed_cur   = speed_img_reg[port_sel];
            pull_cur    = pull_img_reg[port_sel];
            altfunc_cur = altfunc_img_reg[port_sel];
        end
        else
        begin
            mode_cur    = '0;
            otype_cur   = '0;
            speed_cur   = '0;
            pull_cur    = '0;
            altfunc_cur = '0;
        end

        mode_new    = mode_cur;
        otype_new   = otype_cur;
        speed_new   = speed_cur;
        pull_new    = pull_cur;
        altfunc_new = altfunc_cur;
        source_new  = source_reg;
        rise_new    = rise_reg;
        fall_new    = fall_reg;
        enable_new  = enable_reg;

        if (do_alloc)
        begin
            mode_new  = (mode_cur & ~(32'(3) << sh2)) | (32'(cmd_reg.mode) << sh2);
            otype_new = cmd_reg.open_drain ? (otype_cur | pin_bit) : (otype_cur & ~pin_bit);
            speed_new = (speed_cur & ~(32'(3) << sh2)) | (32'(cmd_reg.speed) << sh2);
            pull_new  = (pull_cur & ~(32'(3) << sh2)) | (32'(cmd_reg.pull) << sh2);
            if (cmd_reg.mode == MODE_ALT)
            begin
                altfunc_new = (altfunc_cur & ~(64'(4'hF) << sh4))
                              | (64'(cmd_reg.alt_func) << sh4);
            end
        end

        if (do_irq)
        begin
            source_new = (source_reg & ~(64'(4'hF) << sh4)) | (64'(cmd_reg.port) << sh4);
            unique case (cmd_reg.edge_mode)
                EDGE_RISE:
                begin
                    rise_new = rise_reg | pin_bit;
                    fall_new = fall_reg & ~pin_bit;
                end
                EDGE_FALL:
                begin
                    rise_new = rise_reg & ~pin_bit;
                    fall_new = fall_reg | pin_bit;
                end
                EDGE_BOTH:
                begin
                    rise_new = rise_reg | pin_bit;
                    fall_new = fall_reg | pin_bit;
                end
                default:
                begin
                    rise_new = rise_reg;
                    fall_new = fall_reg;
                end
            endcase
            enable_new = enable_reg | pin_bit;
        end

        priority if (!do_irq)
        begin
            group = '0;
        end
        else if (cmd_reg.pin < PIN_MID_LO)
        begin
            group = cmd_reg.pin[2:0];
        end
        else if (cmd_reg.pin < PIN_HIGH_LO)
        begin
            group = GROUP_MID;
        end
        else
        begin
            group = GROUP_HIGH;
        end

        res_next.status       = !pin_ok || ((cmd_reg.op == OP_REQUEST) && alloc_hit && mismatch);
        res_next.mode_word    = mode_new;
        res_next.otype_word   = otype_new;
        res_next.speed_word   = speed_new;
        res_next.pull_word    = pull_new;
        res_next.altfunc_word = altfunc_new;
        res_next.line_source  = source_new;
        res_next.rise_mask    = rise_new;
        res_next.fall_mask    = fall_new;
        res_next.line_enable  = enable_new;
        res_next.irq_valid    = do_irq;
        res_next.irq_group    = group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
            alloc_reg     <= '0;
            source_reg    <= '0;
            rise_reg      <= '0;
            fall_reg      <= '0;
            enable_reg    <= '0;
            for (int i = 0; i < PORTS; i++)
            begin
                mode_img_reg[i]    <= '0;
                otype_img_reg[i]   <= '0;
                speed_img_reg[i]   <= '0;
                pull_img_reg[i]    <= '0;
                altfunc_img_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                res_valid_reg <= 1'b1;
                source_reg    <= source_new;
                rise_reg      <= rise_new;
                fall_reg      <= fall_new;
                enable_reg    <= enable_new;
                if (do_alloc)
                begin
                    alloc_reg[idx_reg]        <= 1'b1;
                    mode_img_reg[port_sel]    <= mode_new;
                    otype_img_reg[port_sel]   <= otype_new;
                    speed_img_reg[port_sel]   <= speed_new;
                    pull_img_reg[port_sel]    <= pull_new;
                    altfunc_img_reg[port_sel] <= altfunc_new;
                end
                else if (cmd_reg.op == OP_RELEASE)
                begin
                    alloc_reg[idx_reg] <= 1'b0;
                end
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && do_alloc)
        begin
            settings_mem[idx_reg] <= new_set;
        end
        if (pop)
        begin
            cmd_reg <= head;
            idx_reg <= rd_idx;
            if (fire && do_alloc && (idx_reg == rd_idx))
            begin
                rd_data_reg <= new_set;
            end
            else
            begin
                rd_data_reg <= settings_mem[rd_idx];
            end
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

>>> rtl/core/pin_mux_allocator.sv
`timescale 1ns / 1ps
// Pin mux allocator: each request either claims one port/pin with its mode, output type,
// speed, pull, alternate function and edge settings, or releases it, and returns one result
// with the addressed port's register images and the interrupt line state. Requests pass
// through a two-entry queue to the execute unit, which works on each in two overlapped
// steps: one to read the per-pin settings table, one to update the images and load the
// result register. Back to back requests sustain one result per cycle unless a stalled
// result holds the execute unit; the queue keeps accepting until full. Results come out
// in request order.
module pin_mux_allocator
    import pmux_pkg::*;
#(
    parameter int PORTS = 9
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    cmd_t      front_cmd;
    cmd_t      q_head;
    q_status_t q_status;
    logic      q_pop;

    pmux_front #(
        .PORTS (PORTS)
    ) u_front (
        .req_data (req_data),
        .cmd      (front_cmd)
    );

    pmux_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_valid && !q_status.full),
        .push_data (front_cmd),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    pmux_back #(
        .PORTS (PORTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_status  (q_status),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    assign req_stall = q_status.full;

endmodule

>>> rtl/core/pmux_checker.sv
`timescale 1ns / 1ps
module pmux_checker
    import pmux_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_stall,
    input res_t res_data
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    a_group_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.irq_valid |-> res_data.irq_group == 3'd0)
        else $error("line group without enabled line");

    a_irq_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.irq_valid |-> !res_data.status && res_data.line_enable != 16'd0)
        else $error("line enabled on failed request");

    a_edge_enable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.rise_mask | res_data.fall_mask) == res_data.line_enable)
        else $error("edge masks disagree with line enable");

endmodule

bind pin_mux_allocator pmux_checker u_pmux_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
    import pmux_pkg::*;

    localparam int PORTS          = 9;
    localparam int RANDOM_REQS    = 1400;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic       KIND_REQUEST = 1'b0;
    localparam logic [1:0] MODE_OUTPUT  = 2'd1;
    localparam logic [1:0] MODE_ANALOG  = 2'd3;

    typedef struct packed {
        req_t req;
        logic fixed;
        logic fixed_status;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_data;

    logic             pin_taken   [PORTS*16] = '{default: '0};
    logic [SET_W-1:0] pin_cfg     [PORTS*16] = '{default: '0};
    logic [31:0]      mode_img    [PORTS]    = '{default: '0};
    logic [15:0]      otype_img   [PORTS]    = '{default: '0};
    logic [31:0]      speed_img   [PORTS]    = '{default: '0};
    logic [31:0]      pull_img    [PORTS]    = '{default: '0};
    logic [63:0]      altfunc_img [PORTS]    = '{default: '0};
    logic [63:0]      line_src  = '0;
    logic [15:0]      rise_bits = '0;
    logic [15:0]      fall_bits = '0;
    logic [15:0]      line_en   = '0;

    res_t     results_due [$];
    dir_row_t dir_tab [$];
    int       mismatches   = 0;
    int       quiet_cycles = 0;
    int       stall_left   = 0;
    bit       calm         = 1'b0;

    pin_mux_allocator #(.PORTS(PORTS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #10 clk = ~clk;

    function automatic req_t mk_req(logic kind, logic [3:0] port, logic [4:0] pin,
                                    logic [1:0] mode, logic od, logic [1:0] spd,
                                    logic [1:0] pl, logic [3:0] af, logic [1:0] edge_m);
        req_t r;
        r.kind       = kind;
        r.port       = port;
        r.pin        = pin;
        r.mode       = mode;
        r.open_drain = od;
        r.speed      = spd;
        r.pull       = pl;
        r.alt_func   = af;
        r.edge_mode  = edge_m;
        return r;
    endfunction

    function automatic res_t predict_pin_result(req_t r);
        res_t             e;
        int               p;
        int               n;
        int               idx;
        logic [SET_W-1:0] cfg;
        logic [SET_W-1:0] cmp_mask;
        e   = '0;
        p   = r.port;
        n   = r.pin;
        cfg = {r.alt_func, r.pull, r.speed, r.open_drain, r.mode};
        if (p >= PORTS || r.pin > PIN_MAX)
        begin
            e.status = 1'b1;
        end
        else
        begin
            idx = p * 16 + n;
            if (r.kind == KIND_RELEASE)
            begin
                pin_taken[idx] = 1'b0;
            end
            else if (pin_taken[idx])
            begin
                cmp_mask = (r.mode == MODE_ALT) ? SET_MASK_ALT : SET_MASK_BASE;
                if (((pin_cfg[idx] ^ cfg) & cmp_mask) != '0)
                    e.status = 1'b1;
            end
            else
            begin
                mode_img[p][n*2 +: 2]  = r.mode;
                otype_img[p][n]        = r.open_drain;
                speed_img[p][n*2 +: 2] = r.speed;
                pull_img[p][n*2 +: 2]  = r.pull;
                if (r.mode == MODE_ALT)
                    altfunc_img[p][n*4 +: 4] = r.alt_func;
                if (r.mode == MODE_INPUT && r.edge_mode != EDGE_NONE)
                begin
                    line_src[n*4 +: 4] = r.port;
                    rise_bits[n]       = (r.edge_mode != EDGE_FALL);
                    fall_bits[n]       = (r.edge_mode != EDGE_RISE);
                    line_en[n]         = 1'b1;
                    e.irq_valid        = 1'b1;
                    if (n < PIN_MID_LO)
                        e.irq_group = 3'(n);
                    else if (n < PIN_HIGH_LO)
                        e.irq_group = GROUP_MID;
                    else
                        e.irq_group = GROUP_HIGH;
                end
                pin_taken[idx] = 1'b1;
                pin_cfg[idx]   = cfg;
            end
        end
        if (p < PORTS)
        begin
            e.mode_word    = mode_img[p];
            e.otype_word   = otype_img[p];
            e.speed_word   = speed_img[p];
            e.pull_word    = pull_img[p];
            e.altfunc_word = altfunc_img[p];
        end
        e.line_source = line_src;
        e.rise_mask   = rise_bits;
        e.fall_mask   = fall_bits;
        e.line_enable = line_en;
        return e;
    endfunction

    function automatic req_t random_pin_req();
        req_t             r;
        int               pick;
        int               idx;
        logic [SET_W-1:0] cfg;
        pick         = $urandom_range(0, 99);
        r.kind       = KIND_REQUEST;
        r.port       = 4'($urandom_range(0, PORTS - 1));
        r.pin        = 5'($urandom_range(0, 15));
        r.mode       = 2'($urandom);
        r.open_drain = 1'($urandom);
        r.speed      = 2'($urandom);
        r.pull       = 2'($urandom);
        r.alt_func   = 4'($urandom);
        r.edge_mode  = 2'($urandom);
        idx          = r.port * 16 + r.pin;
        if (pick < 10)
        begin
            r.kind = 1'($urandom);
            r.port = 4'($urandom);
            r.pin  = 5'($urandom);
        end
        else if (pick < 38)
        begin
            r.kind = KIND_RELEASE;
        end
        else if (pick < 70 && pin_taken[idx])
        begin
            cfg = pin_cfg[idx];
            if (pick < 48)
                cfg = cfg ^ (SET_W'(1) << $urandom_range(0, SET_W - 1));
            {r.alt_func, r.pull, r.speed, r.open_drain, r.mode} = cfg;
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < 50)
            $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic send_pin_req(req_t r, logic fixed, logic fixed_status);
        res_t want;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        want = predict_pin_result(r);
        if (fixed)
        begin
            want        = '0;
            want.status = fixed_status;
        end
        results_due.push_back(want);
    endtask

    task automatic wait_results_drained();
        req_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || calm)
        begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                res_stall <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            res_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 14);
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (results_due.size() == 0)
            begin
                report_mismatch("result with no request pending");
            end
            else
            begin
                want = results_due.pop_front();
                compare_field("status", res_data.status, want.status);
                compare_field("mode_word", res_data.mode_word, want.mode_word);
                compare_field("otype_word", res_data.otype_word, want.otype_word);
                compare_field("speed_word", res_data.speed_word, want.speed_word);
                compare_field("pull_word", res_data.pull_word, want.pull_word);
                compare_field("altfunc_word", res_data.altfunc_word, want.altfunc_word);
                compare_field("line_source", res_data.line_source, want.line_source);
                compare_field("rise_mask", res_data.rise_mask, want.rise_mask);
                compare_field("fall_mask", res_data.fall_mask, want.fall_mask);
                compare_field("line_enable", res_data.line_enable, want.line_enable);
                compare_field("irq_valid", res_data.irq_valid, want.irq_valid);
                compare_field("irq_group", res_data.irq_group, want.irq_group);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd15, 5'd0, MODE_OUTPUT,
            1'b1, 2'd3, 2'd3, 4'hF, EDGE_BOTH), 1'b1, 1'b1}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_RELEASE, 4'd9, 5'd31, MODE_INPUT,
            1'b0, 2'd0, 2'd0, 4'h0, EDGE_NONE), 1'b1, 1'b1}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd0, 5'd31, MODE_INPUT,
            1'b0, 2'd0, 2'd0, 4'h0, EDGE_RISE), 1'b1, 1'b1}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd0, 5'd16, MODE_ALT,
            1'b1, 2'd1, 2'd2, 4'h5, EDGE_FALL), 1'b1, 1'b1}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_RELEASE, 4'd8, 5'd15, MODE_INPUT,
            1'b0, 2'd0, 2'd0, 4'h0, EDGE_NONE), 1'b1, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd0, 5'd0, MODE_INPUT,
            1'b0, 2'd0, 2'd0, 4'h0, EDGE_RISE), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd0, 5'd0, MODE_INPUT,
            1'b0, 2'd0, 2'd0, 4'h0, EDGE_RISE), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd0, 5'd0, MODE_INPUT,
            1'b0, 2'd1, 2'd0, 4'h0, EDGE_RISE), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_RELEASE, 4'd0, 5'd0, MODE_INPUT,
            1'b0, 2'd0, 2'd0, 4'h0, EDGE_NONE), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd0, 5'd0, MODE_INPUT,
            1'b0, 2'd1, 2'd0, 4'h0, EDGE_NONE), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd8, 5'd15, MODE_ALT,
            1'b1, 2'd3, 2'd3, 4'hF, EDGE_BOTH), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd8, 5'd15, MODE_ALT,
            1'b1, 2'd3, 2'd3, 4'hE, EDGE_BOTH), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd8, 5'd14, MODE_OUTPUT,
            1'b1, 2'd2, 2'd1, 4'h7, EDGE_FALL), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd8, 5'd14, MODE_OUTPUT,
            1'b1, 2'd2, 2'd1, 4'h0, EDGE_NONE), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd1, 5'd7, MODE_INPUT,
            1'b0, 2'd1, 2'd2, 4'h3, EDGE_FALL), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd2, 5'd12, MODE_INPUT,
            1'b1, 2'd2, 2'd1, 4'hA, EDGE_BOTH), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd3, 5'd4, MODE_INPUT,
            1'b0, 2'd3, 2'd0, 4'h1, EDGE_NONE), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd4, 5'd7, MODE_INPUT,
            1'b0, 2'd0, 2'd1, 4'h2, EDGE_RISE), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd5, 5'd3, MODE_ANALOG,
            1'b1, 2'd1, 2'd3, 4'h9, EDGE_RISE), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd1, 5'd7, MODE_INPUT,
            1'b0, 2'd1, 2'd2, 4'h3, EDGE_BOTH), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd8, 5'd20, MODE_INPUT,
            1'b0, 2'd0, 2'd0, 4'h0, EDGE_RISE), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_RELEASE, 4'd12, 5'd3, MODE_INPUT,
            1'b0, 2'd0, 2'd0, 4'h0, EDGE_NONE), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd7, 5'd9, MODE_INPUT,
            1'b1, 2'd2, 2'd2, 4'h6, EDGE_BOTH), 1'b0, 1'b0}));
        dir_tab.push_back(dir_row_t'({mk_req(KIND_REQUEST, 4'd6, 5'd10, MODE_INPUT,
            1'b0, 2'd3, 2'd1, 4'hC, EDGE_RISE), 1'b0, 1'b0}));

        foreach (dir_tab[i])
            send_pin_req(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].fixed_status);
        wait_results_drained();

        for (k = 0; k < RANDOM_REQS; k++)
        begin
            calm = (k >= 500 && k < 600) || (k >= RANDOM_REQS - 150);
            if (k == 800)
                wait_results_drained();
            send_pin_req(random_pin_req(), 1'b0, 1'b0);
        end

        wait_results_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/pmux_pkg.sv
rtl/core/pmux_queue.sv
rtl/core/pmux_front.sv
rtl/core/pmux_back.sv
rtl/core/pin_mux_allocator.sv
rtl/core/pmux_checker.sv
test/tb.sv
